### design/spbar_pkg.sv
// Shared constants, types and register codes of the spectrum bar LED mapper.
`default_nettype none

package spbar_pkg;

   // Design sizes.
   localparam int BANDS        = 20;
   localparam int BAR_HEIGHT   = 16;
   localparam int FILTER_DEPTH = 4;
   localparam int LED_COUNT    = 320;
   localparam int SAMPLE_BITS  = 16;

   // Port field widths.
   localparam int MAG_W        = 16;
   localparam int BAND_FIELD_W = 5;
   localparam int LEVEL_W      = 4;
   localparam int LED_W        = 9;
   localparam int CH_W         = 8;
   localparam int COLOR_W      = 24;
   localparam int POS_W        = 5;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 24;

   // Derived internal widths.
   localparam int BAND_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int SLOT_W  = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
   localparam int FILL_W  = $clog2(FILTER_DEPTH + 1);
   localparam int KW      = $clog2(BAR_HEIGHT);
   localparam int HDEPTH  = BANDS * FILTER_DEPTH;
   localparam int HADDR_W = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
   localparam int TDEPTH  = BANDS * BAR_HEIGHT;
   localparam int TADDR_W = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

   // Mean over the ring plus the new sample: divide by a constant through a
   // reciprocal multiply and one correction step.
   localparam int DIVISOR = FILTER_DEPTH + 1;
   localparam int SUM_W   = MAG_W + $clog2(DIVISOR);
   localparam int PROD_W  = 2 * SUM_W;
   localparam logic [SUM_W-1:0] REC_MUL = SUM_W'((1 << SUM_W) / DIVISOR);

   localparam logic [MAG_W-1:0] SAMPLE_MASK =
      (SAMPLE_BITS >= MAG_W) ? {MAG_W{1'b1}} : MAG_W'((1 << SAMPLE_BITS) - 1);

   // Register reset values.
   localparam logic [POS_W-1:0]   AMBER_START_RESET  = POS_W'(10);
   localparam logic [POS_W-1:0]   RED_START_RESET    = POS_W'(13);
   localparam logic [COLOR_W-1:0] COLOR_NORMAL_RESET = 24'h002000;
   localparam logic [COLOR_W-1:0] COLOR_AMBER_RESET  =
      COLOR_W'(((8'hff % 50) << 16) | ((8'hbf % 50) << 8));
   localparam logic [COLOR_W-1:0] COLOR_RED_RESET    = 24'h200000;
   localparam logic [COLOR_W-1:0] COLOR_DARK_RESET   = 24'h000000;

   // Input commands.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TABLE  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AMBER_START,
      CSR_RED_START,
      CSR_COLOR_NORMAL,
      CSR_COLOR_AMBER,
      CSR_COLOR_RED,
      CSR_COLOR_DARK
   } csr_index_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [MAG_W-1:0] sample;
   } avg_req_type;

endpackage

`default_nettype wire

### design/spbar_ram.sv
// Generic single-write, single-read memory with a registered read port.
`default_nettype none

module spbar_ram #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/spbar_avg.sv
// Three-stage smoothing unit: divides the sum by FILTER_DEPTH + 1 and floors at the sample.
`default_nettype none

module spbar_avg import spbar_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire avg_req_type      req,
   output logic                  done,
   output logic      [MAG_W-1:0] avg
);

   logic              v1_ff, v2_ff, done_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SUM_W-1:0]  sum1_ff, sum2_ff;
   logic [MAG_W-1:0]  samp1_ff, samp2_ff;
   logic [SUM_W-1:0]  q0_ff, q0_in;
   logic [SUM_W-1:0]  rem;
   logic [SUM_W-1:0]  q_fix;
   logic [MAG_W-1:0]  q_mag;
   logic [MAG_W-1:0]  avg_ff, avg_in;

   always_comb begin
      prod_in = PROD_W'(req.sum) * PROD_W'(REC_MUL);
      q0_in   = prod_ff[PROD_W-1:SUM_W];
      // The truncated reciprocal can leave the quotient one short.
      rem     = sum2_ff - SUM_W'(q0_ff * SUM_W'(DIVISOR));
      q_fix   = (rem >= SUM_W'(DIVISOR)) ? q0_ff + SUM_W'(1) : q0_ff;
      q_mag   = q_fix[MAG_W-1:0];
      avg_in  = (q_mag < samp2_ff) ? samp2_ff : q_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= start;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
      prod_ff  <= prod_in;
      sum1_ff  <= req.sum;
      samp1_ff <= req.sample;
      q0_ff    <= q0_in;
      sum2_ff  <= sum1_ff;
      samp2_ff <= samp1_ff;
      avg_ff   <= avg_in;
   end

   assign done = done_ff;
   assign avg  = avg_ff;

endmodule

`default_nettype wire

### design/spectrum_bar_led_mapper.sv
// Top level: sample sequencer, history and threshold memories, pixel output register.
// A sample is not taken until the last pixel of the previous one has been offered;
// pixels leave one a cycle while the output is not stalled.
// A threshold table write gives no pixels.
// After reset all BANDS * FILTER_DEPTH (80) history entries are cleared, one entry a cycle;
// no input beat is taken meanwhile. Configuration registers return to their reset values.
`default_nettype none

module spectrum_bar_led_mapper import spbar_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_cmd,
   input  wire logic [MAG_W-1:0]        req_magnitude,
   input  wire logic                    req_frame_end,
   input  wire logic [BAND_FIELD_W-1:0] req_table_band,
   input  wire logic [LEVEL_W-1:0]      req_table_level,
   input  wire logic [MAG_W-1:0]        req_table_value,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic      [LED_W-1:0]        rsp_led_index,
   output logic      [CH_W-1:0]         rsp_red,
   output logic      [CH_W-1:0]         rsp_green,
   output logic      [CH_W-1:0]         rsp_blue,
   output logic                         rsp_bar_done,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HIST,
      S_AVG,
      S_DIV,
      S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [HADDR_W-1:0] clr_ff, clr_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SLOT_W-1:0]  slot_use;
   logic               frame_start_ff, frame_start_in;
   logic [BAND_W-1:0]  band_ff, band_in;
   logic [SLOT_W-1:0]  cur_slot_ff, cur_slot_in;
   logic [HADDR_W-1:0] hbase_ff, hbase_in;
   logic [TADDR_W-1:0] tbase_ff, tbase_in;
   logic [MAG_W-1:0]   sample_ff, sample_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [FILL_W-1:0]  j_ff, j_in;
   logic [SLOT_W-1:0]  prev_j_ff, prev_j_in;
   logic               odd_ff, odd_in;
   logic [LED_W-1:0]   idx_ff, idx_in;
   logic [KW-1:0]      k_ff, k_in;
   logic               lit_ff, lit_in;
   logic               lit_now;
   logic [MAG_W-1:0]   avg_ff, avg_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [LED_W-1:0]   led_ff, led_in;
   logic [COLOR_W-1:0] rgb_ff, rgb_in;
   logic               done_ff, done_in;
   logic               out_free;

   logic [POS_W-1:0]   amber_start_ff, red_start_ff;
   logic [COLOR_W-1:0] color_normal_ff, color_amber_ff, color_red_ff, color_dark_ff;

   logic               h_wr_en, h_rd_en;
   logic [HADDR_W-1:0] h_wr_addr, h_rd_addr;
   logic [MAG_W-1:0]   h_wr_data, h_rd_data;
   logic               t_wr_en, t_rd_en;
   logic [TADDR_W-1:0] t_wr_addr, t_rd_addr;
   logic [MAG_W-1:0]   t_rd_data;

   logic               avg_start;
   avg_req_type        avg_req;
   logic               avg_done;
   logic [MAG_W-1:0]   avg_out;

   spbar_ram #(.DEPTH(HDEPTH), .WIDTH(MAG_W)) u_hist_ram (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (h_wr_addr),
      .wr_data (h_wr_data),
      .rd_en   (h_rd_en),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_data)
   );

   spbar_ram #(.DEPTH(TDEPTH), .WIDTH(MAG_W)) u_thr_ram (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (t_wr_addr),
      .wr_data (req_table_value),
      .rd_en   (t_rd_en),
      .rd_addr (t_rd_addr),
      .rd_data (t_rd_data)
   );

   assign avg_req.sum    = sum_ff;
   assign avg_req.sample = sample_ff;

   spbar_avg u_avg (
      .clock (clock),
      .reset (reset),
      .start (avg_start),
      .req   (avg_req),
      .done  (avg_done),
      .avg   (avg_out)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign slot_use  = !frame_start_ff ? slot_ff :
                      (slot_ff == SLOT_W'(FILTER_DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
   assign lit_now   = lit_ff && (avg_ff > t_rd_data);

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      slot_in        = slot_ff;
      frame_start_in = frame_start_ff;
      band_in        = band_ff;
      cur_slot_in    = cur_slot_ff;
      hbase_in       = hbase_ff;
      tbase_in       = tbase_ff;
      sample_in      = sample_ff;
      sum_in         = sum_ff;
      j_in           = j_ff;
      prev_j_in      = prev_j_ff;
      odd_in         = odd_ff;
      idx_in         = idx_ff;
      k_in           = k_ff;
      lit_in         = lit_ff;
      avg_in         = avg_ff;
      rsp_valid_in   = rsp_stall ? rsp_valid_ff : 1'b0;
      led_in         = led_ff;
      rgb_in         = rgb_ff;
      done_in        = done_ff;

      h_wr_en   = 1'b0;
      h_wr_addr = hbase_ff + HADDR_W'(cur_slot_ff);
      h_wr_data = sample_ff;
      h_rd_en   = 1'b0;
      h_rd_addr = hbase_ff + HADDR_W'(j_ff);
      t_wr_en   = 1'b0;
      t_wr_addr = TADDR_W'(int'(req_table_band) * BAR_HEIGHT + int'(req_table_level));
      t_rd_en   = 1'b0;
      t_rd_addr = tbase_ff;
      avg_start = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            h_wr_en   = 1'b1;
            h_wr_addr = clr_ff;
            h_wr_data = '0;
            if (clr_ff == HADDR_W'(HDEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + HADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_TABLE) begin
                  // Writes outside the table are dropped.
                  t_wr_en = (int'(req_table_band) < BANDS) &&
                            (int'(req_table_level) < BAR_HEIGHT);
               end else begin
                  slot_in        = slot_use;
                  cur_slot_in    = slot_use;
                  frame_start_in = req_frame_end;
                  band_in        = (req_frame_end || band_ff == BAND_W'(BANDS - 1)) ?
                                   '0 : band_ff + BAND_W'(1);
                  sample_in      = req_magnitude & SAMPLE_MASK;
                  sum_in         = SUM_W'(req_magnitude & SAMPLE_MASK);
                  hbase_in       = HADDR_W'(int'(band_ff) * FILTER_DEPTH);
                  tbase_in       = TADDR_W'(int'(band_ff) * BAR_HEIGHT);
                  odd_in         = band_ff[0];
                  // Even bars run down from their top pixel, odd bars up from their base.
                  idx_in         = band_ff[0] ?
                     LED_W'(LED_COUNT - (int'(band_ff) + 1) * BAR_HEIGHT) :
                     LED_W'(LED_COUNT - 1 - int'(band_ff) * BAR_HEIGHT);
                  j_in           = '0;
                  state_in       = S_HIST;
               end
            end
         end
         S_HIST: begin
            // One ring entry is read per cycle; the entry being replaced is
            // taken from the sample register instead of the memory.
            if (j_ff != FILL_W'(FILTER_DEPTH)) begin
               h_rd_en   = 1'b1;
               prev_j_in = SLOT_W'(j_ff);
               j_in      = j_ff + FILL_W'(1);
            end else begin
               state_in = S_AVG;
            end
            if (j_ff == '0) begin
               h_wr_en = 1'b1;
            end else begin
               sum_in = sum_ff + SUM_W'((prev_j_ff == cur_slot_ff) ? sample_ff : h_rd_data);
            end
         end
         S_AVG: begin
            avg_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (avg_done) begin
               avg_in    = avg_out;
               k_in      = '0;
               lit_in    = 1'b1;
               t_rd_en   = 1'b1;
               t_rd_addr = tbase_ff;
               state_in  = S_EMIT;
            end
         end
         S_EMIT: begin
            // Pixel k is lit while every threshold up to k lies below the average.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               led_in       = idx_ff;
               if (!lit_now) begin
                  rgb_in = color_dark_ff;
               end else if (8'(k_ff) >= 8'(red_start_ff)) begin
                  rgb_in = color_red_ff;
               end else if (8'(k_ff) >= 8'(amber_start_ff)) begin
                  rgb_in = color_amber_ff;
               end else begin
                  rgb_in = color_normal_ff;
               end
               done_in = (k_ff == KW'(BAR_HEIGHT - 1));
               idx_in  = odd_ff ? idx_ff + LED_W'(1) : idx_ff - LED_W'(1);
               lit_in  = lit_now;
               if (k_ff == KW'(BAR_HEIGHT - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  k_in      = k_ff + KW'(1);
                  t_rd_en   = 1'b1;
                  t_rd_addr = tbase_ff + TADDR_W'(k_ff) + TADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         slot_ff        <= '0;
         frame_start_ff <= 1'b1;
         band_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         slot_ff        <= slot_in;
         frame_start_ff <= frame_start_in;
         band_ff        <= band_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cur_slot_ff <= cur_slot_in;
      hbase_ff    <= hbase_in;
      tbase_ff    <= tbase_in;
      sample_ff   <= sample_in;
      sum_ff      <= sum_in;
      j_ff        <= j_in;
      prev_j_ff   <= prev_j_in;
      odd_ff      <= odd_in;
      idx_ff      <= idx_in;
      k_ff        <= k_in;
      lit_ff      <= lit_in;
      avg_ff      <= avg_in;
      led_ff      <= led_in;
      rgb_ff      <= rgb_in;
      done_ff     <= done_in;
   end

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         amber_start_ff  <= AMBER_START_RESET;
         red_start_ff    <= RED_START_RESET;
         color_normal_ff <= COLOR_NORMAL_RESET;
         color_amber_ff  <= COLOR_AMBER_RESET;
         color_red_ff    <= COLOR_RED_RESET;
         color_dark_ff   <= COLOR_DARK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_AMBER_START:  amber_start_ff  <= csr_data[POS_W-1:0];
            CSR_RED_START:    red_start_ff    <= csr_data[POS_W-1:0];
            CSR_COLOR_NORMAL: color_normal_ff <= csr_data[COLOR_W-1:0];
            CSR_COLOR_AMBER:  color_amber_ff  <= csr_data[COLOR_W-1:0];
            CSR_COLOR_RED:    color_red_ff    <= csr_data[COLOR_W-1:0];
            CSR_COLOR_DARK:   color_dark_ff   <= csr_data[COLOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_index = led_ff;
   assign rsp_red       = rgb_ff[23:16];
   assign rsp_green     = rgb_ff[15:8];
   assign rsp_blue      = rgb_ff[7:0];
   assign rsp_bar_done  = done_ff;

   a_no_pixel_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid_ff)
      else $error("pixel offered during history clear");

   a_last_pixel_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free && k_ff == KW'(BAR_HEIGHT - 1))
      |=> (rsp_valid_ff && done_ff && state_ff == S_IDLE))
      else $error("last pixel of a bar not flagged");

   a_avg_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      avg_done |-> state_ff == S_DIV)
      else $error("average result arrived outside its wait state");

   a_ring_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HIST |-> j_ff <= FILL_W'(FILTER_DEPTH))
      else $error("ring read counter ran past the ring");

endmodule

`default_nettype wire
